@@ hdl/sppe_pkg.sv @@
// Package for the septic path point evaluator.
// Holds shared widths, function codes, the stage control struct and the term weight and skip functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sppe_pkg;

	localparam int TERM_COUNT_DEF = 8;
	localparam int COEF_W = 32;
	localparam int U_W = 17;
	localparam int ACC_W = 49;
	localparam int RES_W = 48;
	localparam int WGT_W = 8;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_POINT = 2'd1;
	localparam logic [1:0] FUNC_D1 = 2'd2;
	localparam logic [1:0] FUNC_D2 = 2'd3;

	localparam logic [U_W-1:0] U_ONE = 17'd65536;

	typedef struct packed {
		logic valid;
		logic [1:0] func;
		logic [U_W-1:0] u;
	} sppe_ctl_t;

	// Derivative weight of the term of power idx: 1, i or i(i-1).
	function automatic logic [WGT_W-1:0] term_weight(input logic [1:0] func, input int idx);
		int w;
		begin
			case (func)
				FUNC_D1: w = idx;
				FUNC_D2: w = idx * (idx - 1);
				default: w = 1;
			endcase
			term_weight = WGT_W'(w);
		end
	endfunction

	// Terms below the derivative order drop out; the accumulator passes through.
	function automatic logic term_skip(input logic [1:0] func, input int idx);
		begin
			case (func)
				FUNC_D1: term_skip = (idx < 1);
				FUNC_D2: term_skip = (idx < 2);
				default: term_skip = 1'b0;
			endcase
		end
	endfunction

endpackage
`default_nettype wire

@@ hdl/sppe_cell.sv @@
// One cell of the Horner chain: holds the x and y coefficients of one power of u.
// Depends on sppe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sppe_cell #(
	parameter int IDX = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic advance,
	input wire logic wr_en,
	input wire logic wr_axis,
	input wire logic [2:0] wr_power,
	input wire logic signed [sppe_pkg::COEF_W-1:0] wr_value,
	input wire sppe_pkg::sppe_ctl_t ctl_in,
	input wire logic signed [sppe_pkg::ACC_W-1:0] acc_x_in,
	input wire logic signed [sppe_pkg::ACC_W-1:0] acc_y_in,
	output sppe_pkg::sppe_ctl_t ctl_q,
	output logic signed [sppe_pkg::ACC_W-1:0] acc_x_q,
	output logic signed [sppe_pkg::ACC_W-1:0] acc_y_q
);

	localparam int PROD_W = sppe_pkg::ACC_W + sppe_pkg::U_W + 1;
	localparam int TERM_W = sppe_pkg::COEF_W + sppe_pkg::WGT_W + 1;

	logic signed [sppe_pkg::COEF_W-1:0] coef_x_q;
	logic signed [sppe_pkg::COEF_W-1:0] coef_y_q;
	logic hit;
	logic skip;
	logic signed [sppe_pkg::WGT_W:0] wgt;
	logic signed [sppe_pkg::U_W:0] u_s;
	logic signed [PROD_W-1:0] prod_x;
	logic signed [PROD_W-1:0] prod_y;
	logic signed [PROD_W-1:0] rnd_x;
	logic signed [PROD_W-1:0] rnd_y;
	logic signed [TERM_W-1:0] term_x;
	logic signed [TERM_W-1:0] term_y;
	logic signed [sppe_pkg::ACC_W-1:0] nxt_x;
	logic signed [sppe_pkg::ACC_W-1:0] nxt_y;

	assign hit = wr_en && (32'(wr_power) == 32'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q <= '0;
			coef_y_q <= '0;
		end else if (hit) begin
			if (wr_axis) coef_y_q <= wr_value;
			else coef_x_q <= wr_value;
		end
	end

	always_comb begin
		skip = sppe_pkg::term_skip(ctl_in.func, IDX);
		wgt = $signed({1'b0, sppe_pkg::term_weight(ctl_in.func, IDX)});
		u_s = $signed({1'b0, ctl_in.u});
		prod_x = acc_x_in * u_s;
		prod_y = acc_y_in * u_s;
		// round to nearest, ties toward plus infinity
		rnd_x = (prod_x + PROD_W'(32768)) >>> 16;
		rnd_y = (prod_y + PROD_W'(32768)) >>> 16;
		term_x = coef_x_q * wgt;
		term_y = coef_y_q * wgt;
		if (skip) begin
			nxt_x = acc_x_in;
			nxt_y = acc_y_in;
		end else begin
			nxt_x = rnd_x[sppe_pkg::ACC_W-1:0] + sppe_pkg::ACC_W'(term_x);
			nxt_y = rnd_y[sppe_pkg::ACC_W-1:0] + sppe_pkg::ACC_W'(term_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (advance) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			acc_x_q <= nxt_x;
			acc_y_q <= nxt_y;
		end
	end

endmodule
`default_nettype wire

@@ hdl/septic_path_point_evaluator.sv @@
// Top level of the septic path point evaluator: input decode, cell chain, output register.
// Depends on sppe_pkg and sppe_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item. A write
//   transaction (func 0) loads coefficient power_index of row axis at once and
//   returns nothing; power_index at or beyond TERM_COUNT is dropped. An evaluation
//   transaction (func 1..3) clamps param_u to [0,1.0] and walks a chain of
//   TERM_COUNT cells, highest power first, one Horner step per cell per cycle unless held.
//   Output channel (out_valid/out_ready) returns x_result, y_result, saturated.
// Flow through the chain:
//   The top cell loads at the accepting edge, then each further cell in turn and
//   then the output register, which raises out_valid. One evaluation is in the
//   chain at a time, since in_ready stays low while any cell is busy: a new
//   transaction is taken the cycle after the last cell hands off, while a
//   finished result may still wait at the output.
// Reset:
//   arst_n clears the chain valid flags and out_valid and zeroes all coefficients.
// Stall:
//   When the output waits and a new result reaches the end of the chain, the
//   whole chain holds and in_ready stays low until the output is taken.
`timescale 1ns / 1ps
`default_nettype none
module septic_path_point_evaluator #(
	parameter int TERM_COUNT = sppe_pkg::TERM_COUNT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] func,
	input wire logic axis,
	input wire logic [2:0] power_index,
	input wire logic signed [31:0] coeff_value,
	input wire logic signed [17:0] param_u,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [47:0] x_result,
	output logic signed [47:0] y_result,
	output logic saturated
);

	localparam int AW = sppe_pkg::ACC_W;
	localparam int RW = sppe_pkg::RES_W;

	sppe_pkg::sppe_ctl_t ctl_chain [TERM_COUNT:0];
	logic signed [AW-1:0] accx_chain [TERM_COUNT:0];
	logic signed [AW-1:0] accy_chain [TERM_COUNT:0];
	logic [TERM_COUNT-1:0] cell_busy;
	logic in_fire;
	logic wr_en;
	logic advance;
	logic [sppe_pkg::U_W-1:0] u_clamped;
	logic out_valid_q;
	logic signed [RW-1:0] x_q;
	logic signed [RW-1:0] y_q;
	logic sat_q;
	logic sat_x;
	logic sat_y;
	logic signed [RW-1:0] x_sat;
	logic signed [RW-1:0] y_sat;

	assign in_fire = in_valid && in_ready;
	assign wr_en = in_fire && (func == sppe_pkg::FUNC_WRITE);
	assign in_ready = ~|cell_busy;

	// Clamp u: negative to zero, above 1.0 to 1.0.
	always_comb begin
		if (param_u[17]) u_clamped = '0;
		else if (param_u[16:0] > sppe_pkg::U_ONE) u_clamped = sppe_pkg::U_ONE;
		else u_clamped = param_u[16:0];
	end

	// Launch the evaluation into the top cell with an empty accumulator.
	always_comb begin
		ctl_chain[TERM_COUNT].valid = in_fire && (func != sppe_pkg::FUNC_WRITE);
		ctl_chain[TERM_COUNT].func = func;
		ctl_chain[TERM_COUNT].u = u_clamped;
		accx_chain[TERM_COUNT] = '0;
		accy_chain[TERM_COUNT] = '0;
	end

	// Hold the chain only when a result reaches the end and the output is blocked.
	assign advance = !(ctl_chain[0].valid && out_valid_q && !out_ready);

	genvar gi;
	generate
		for (gi = 0; gi < TERM_COUNT; gi++) begin : g_cell
			sppe_cell #(.IDX(gi)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.advance  (advance),
				.wr_en    (wr_en),
				.wr_axis  (axis),
				.wr_power (power_index),
				.wr_value (coeff_value),
				.ctl_in   (ctl_chain[gi+1]),
				.acc_x_in (accx_chain[gi+1]),
				.acc_y_in (accy_chain[gi+1]),
				.ctl_q    (ctl_chain[gi]),
				.acc_x_q  (accx_chain[gi]),
				.acc_y_q  (accy_chain[gi])
			);
			assign cell_busy[gi] = ctl_chain[gi].valid;
		end
	endgenerate

	// Saturate to the 48-bit result range.
	always_comb begin
		sat_x = accx_chain[0][AW-1] != accx_chain[0][AW-2];
		sat_y = accy_chain[0][AW-1] != accy_chain[0][AW-2];
		if (sat_x) x_sat = accx_chain[0][AW-1] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
		else x_sat = accx_chain[0][RW-1:0];
		if (sat_y) y_sat = accy_chain[0][AW-1] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
		else y_sat = accy_chain[0][RW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl_chain[0].valid && advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_chain[0].valid && advance) begin
			x_q <= x_sat;
			y_q <= y_sat;
			sat_q <= sat_x || sat_y;
		end
	end

	assign out_valid = out_valid_q;
	assign x_result = x_q;
	assign y_result = y_q;
	assign saturated = sat_q;

	// Only one evaluation is ever in the chain.
	a_one_in_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_busy))
		else $error("more than one evaluation in the cell chain");

	// An accepted evaluation enters the top cell on the next edge.
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && func != sppe_pkg::FUNC_WRITE) |=> ctl_chain[TERM_COUNT-1].valid)
		else $error("evaluation lost at launch");

	// A result leaving the chain lands in the output register.
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_chain[0].valid && advance) |=> out_valid_q)
		else $error("result lost at output");

endmodule
`default_nettype wire

@@ bench/tb_septic_path_point_evaluator.sv @@
// Testbench for septic_path_point_evaluator: loads coefficient tables and checks
// point, first and second derivative results against a Horner predictor kept here.
// Depends on sppe_pkg and the septic_path_point_evaluator RTL.
`timescale 1ns / 1ps
module tb_septic_path_point_evaluator;

	localparam int TERMS = sppe_pkg::TERM_COUNT_DEF;

	typedef struct {
		logic signed [47:0] x;
		logic signed [47:0] y;
		logic sat;
	} path_sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = sppe_pkg::FUNC_WRITE;
	logic axis = 1'b0;
	logic [2:0] power_index = 3'd0;
	logic signed [31:0] coeff_value = 32'sd0;
	logic signed [17:0] param_u = 18'sd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [47:0] x_result;
	logic signed [47:0] y_result;
	logic saturated;

	// Predictor copy of the coefficient table, x row then y row.
	logic signed [31:0] coef_table [2][TERMS];
	path_sample_t pending_samples [$];
	int mismatch_count = 0;
	int sample_count = 0;
	int hold_off_cycles = 0;
	bit stall_bias = 1'b0;

	septic_path_point_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .axis(axis), .power_index(power_index),
		.coeff_value(coeff_value), .param_u(param_u),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_result(x_result), .y_result(y_result), .saturated(saturated)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Gap length: mostly zero or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Horner evaluation of one row; weights i or i(i-1) for the derivatives.
	function automatic logic signed [63:0] horner_row(int row, int order, longint u);
		longint acc;
		longint term;
		longint wgt;
		acc = 0;
		for (int i = TERMS - 1; i >= order; i--) begin
			wgt = (order == 0) ? 1 : (order == 1) ? i : i * (i - 1);
			term = longint'(coef_table[row][i]) * wgt;
			if (i == TERMS - 1)
				acc = term;
			else
				acc = ((acc * u + 32768) >>> 16) + term;
		end
		return acc;
	endfunction

	function automatic path_sample_t predict_sample(logic [1:0] f, logic signed [17:0] pu);
		path_sample_t s;
		longint u;
		longint v [2];
		longint lim_hi;
		longint lim_lo;
		lim_hi = 64'sd140737488355327;
		lim_lo = -lim_hi - 1;
		u = pu;
		if (u < 0) u = 0;
		if (u > 65536) u = 65536;
		s.sat = 1'b0;
		for (int r = 0; r < 2; r++) begin
			v[r] = horner_row(r, int'(f) - 1, u);
			if (v[r] > lim_hi) begin v[r] = lim_hi; s.sat = 1'b1; end
			if (v[r] < lim_lo) begin v[r] = lim_lo; s.sat = 1'b1; end
		end
		s.x = v[0][47:0];
		s.y = v[1][47:0];
		return s;
	endfunction

	// Offer one transaction, hold it until accepted, update the predictor.
	// With no gap, valid stays high for the next transaction.
	task automatic send_item(logic [1:0] f, logic a, logic [2:0] p,
			logic signed [31:0] c, logic signed [17:0] pu);
		int g;
		func <= f;
		axis <= a;
		power_index <= p;
		coeff_value <= c;
		param_u <= pu;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (f == sppe_pkg::FUNC_WRITE)
			coef_table[a][p] = c;
		else
			pending_samples.push_back(predict_sample(f, pu));
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_coef(logic a, logic [2:0] p, logic signed [31:0] c);
		send_item(sppe_pkg::FUNC_WRITE, a, p, c, 18'($urandom));
	endtask

	task automatic evaluate(logic [1:0] f, logic signed [17:0] pu);
		send_item(f, 1'($urandom), 3'($urandom), 32'($urandom), pu);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [17:0] rand_u();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 18'sh20000 | 18'($urandom);
		if (r == 1) return 18'sd65536 + 18'($urandom_range(1, 65535));
		if (r == 2) return 18'sd65536;
		if (r == 3) return 18'sd0;
		return 18'($urandom_range(0, 65536));
	endfunction

	function automatic logic signed [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom_range(0, 131071)) - 32'sd65536;
			default: return 32'($urandom);
		endcase
	endfunction

	// Directed: extreme coefficients and every function, clamp edges of u.
	task automatic test_directed();
		for (int p = 0; p < TERMS; p++) begin
			write_coef(1'b0, 3'(p), 32'sh7fffffff);
			write_coef(1'b1, 3'(p), 32'sh80000000);
		end
		evaluate(sppe_pkg::FUNC_POINT, 18'sd65536);
		evaluate(sppe_pkg::FUNC_D1, 18'sh1ffff);
		evaluate(sppe_pkg::FUNC_D2, 18'sh20000);
		evaluate(sppe_pkg::FUNC_POINT, 18'sd0);
		evaluate(sppe_pkg::FUNC_D2, 18'sd32768);
		evaluate(sppe_pkg::FUNC_D1, -18'sd1);
	endtask

	// Random tables and evaluations; mostly evaluations on fresh coefficients.
	task automatic test_random(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 2) == 0)
				write_coef(1'($urandom), 3'($urandom), rand_coef());
			else
				evaluate(2'($urandom_range(1, 3)), rand_u());
		end
	endtask

	// Receiver holds off for a long stretch while evaluations queue up.
	task automatic test_backpressure();
		hold_off_cycles = 200;
		for (int n = 0; n < 20; n++)
			evaluate(2'($urandom_range(1, 3)), rand_u());
		wait_drained();
	endtask

	// Sender pauses until all results are back, then resumes with a receiver biased toward stalls.
	task automatic test_pause_drain();
		test_random(60);
		wait_drained();
		stall_bias = 1'b1;
		test_random(60);
		stall_bias = 1'b0;
		wait_drained();
	endtask

	// Receiver: random ready, with an explicit long hold-off when requested.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			g = stall_bias ? gap_len() + 2 : gap_len();
			out_ready <= (g == 0) || ($urandom_range(0, 1) == 1);
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		path_sample_t exp_s;
		if (arst_n && out_valid && out_ready) begin
			sample_count++;
			if (pending_samples.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result x=%0d y=%0d sat=%0b",
						x_result, y_result, saturated);
			end else begin
				exp_s = pending_samples.pop_front();
				if (exp_s.x !== x_result || exp_s.y !== y_result ||
						exp_s.sat !== saturated) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d: exp x=%0d y=%0d sat=%0b got x=%0d y=%0d sat=%0b",
							sample_count, exp_s.x, exp_s.y, exp_s.sat,
							x_result, y_result, saturated);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb_septic_path_point_evaluator: FAIL");
		$finish;
	end

	initial begin
		bit failed;
		for (int r = 0; r < 2; r++)
			for (int i = 0; i < TERMS; i++)
				coef_table[r][i] = 32'sd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(520);
		test_pause_drain();
		wait_drained();
		repeat (30) @(posedge clk);
		failed = (mismatch_count != 0) || (pending_samples.size() != 0);
		if (!failed)
			$display("tb_septic_path_point_evaluator: PASS");
		else
			$display("tb_septic_path_point_evaluator: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/sppe_pkg.sv
hdl/sppe_cell.sv
hdl/septic_path_point_evaluator.sv
bench/tb_septic_path_point_evaluator.sv
